// ----- rtl/awdt_pkg.sv -----
// awdt_pkg: shared types and constants for the ack window duplicate tracker
// used by awdt_cell, awdt_history and ack_window_duplicate_tracker
package awdt_pkg;

	localparam int unsigned SEQ_W   = 32;
	localparam int unsigned WIN_W   = 32;
	localparam int unsigned SHIFT_W = 6;
	localparam int unsigned IDX_W   = 5;

	// control from the sequencer to the history chain
	typedef struct packed {
		logic             push;
		logic [SEQ_W-1:0] push_val;
		logic [SEQ_W-1:0] key;
	} hist_ctrl_t;

endpackage

// ----- rtl/ack_window_duplicate_tracker.sv -----
// ack_window_duplicate_tracker: one item in, one result out; the item is taken in S_IDLE,
// passes through S_CHECK and S_DECIDE, and the result is registered in S_DONE, after which
// the sequencer returns to S_IDLE for the next item; a forward jump first passes S_DRAIN,
// which makes the history pushes (up to 33, one push per cycle through the chain),
// and a result waiting on m_axis_tready holds off the next item
// arst_n clears window, newest number and history count; history cells use the fill count
module ack_window_duplicate_tracker #(
	parameter int unsigned HISTORY_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] seq_number
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // [31:0] ack_id, [63:32] ack_bits
	output logic [1:0]  m_axis_tuser   // [0] is_duplicate, [1] any_received
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DECIDE,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [awdt_pkg::SEQ_W-1:0]      seq_q;
	logic [awdt_pkg::SEQ_W-1:0]      newest_q;
	logic [awdt_pkg::WIN_W-1:0]      window_q;
	logic                            seen_q;
	logic [awdt_pkg::SEQ_W-1:0]      diff_q;
	logic                            gt_q;
	logic                            eq_q;
	logic [awdt_pkg::SEQ_W-1:0]      base_q;
	logic [awdt_pkg::WIN_W-1:0]      drain_q;
	logic                            last_q;
	logic                            dup_q;

	awdt_pkg::hist_ctrl_t            hctrl;
	logic                            hist_hit;
	logic                            near;
	logic [awdt_pkg::SHIFT_W-1:0]    diff_lo;
	logic [awdt_pkg::SHIFT_W-1:0]    keep_full;
	logic [awdt_pkg::IDX_W-1:0]      keep_sh;
	logic [awdt_pkg::SHIFT_W-1:0]    bit_full;
	logic [awdt_pkg::IDX_W-1:0]      bit_idx;
	logic [awdt_pkg::IDX_W-1:0]      lsb_idx;
	logic                            out_free;

	// window distance decode
	assign diff_lo   = diff_q[awdt_pkg::SHIFT_W-1:0];
	assign near      = (diff_q[awdt_pkg::SEQ_W-1:awdt_pkg::SHIFT_W] == '0) &&
	                   (diff_lo <= awdt_pkg::SHIFT_W'(awdt_pkg::WIN_W));
	assign keep_full = awdt_pkg::SHIFT_W'(awdt_pkg::WIN_W) - diff_lo;
	assign keep_sh   = keep_full[awdt_pkg::IDX_W-1:0];
	assign bit_full  = diff_lo - 1'b1;
	assign bit_idx   = bit_full[awdt_pkg::IDX_W-1:0];
	assign out_free  = !m_axis_tvalid || m_axis_tready;

	// lowest pending bit of the drain mask
	always_comb begin
		lsb_idx = '0;
		for (int i = awdt_pkg::WIN_W - 1; i >= 0; i--) begin
			if (drain_q[i]) begin
				lsb_idx = awdt_pkg::IDX_W'(i);
			end
		end
	end

	// history push and search key
	always_comb begin
		hctrl.key      = seq_q;
		hctrl.push     = 1'b0;
		hctrl.push_val = seq_q;
		case (state_q)
			S_DECIDE: begin
				hctrl.push = seen_q && !eq_q && !gt_q && !near && !hist_hit;
			end
			S_DRAIN: begin
				if (drain_q != '0) begin
					hctrl.push     = 1'b1;
					hctrl.push_val = base_q - awdt_pkg::SEQ_W'(lsb_idx) - 1'b1;
				end else if (last_q) begin
					hctrl.push     = 1'b1;
					hctrl.push_val = base_q;
				end
			end
			default: begin
				hctrl.push = 1'b0;
			end
		endcase
	end

	awdt_history #(
		.DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (hctrl),
		.hit    (hist_hit)
	);

	assign s_axis_tready = (state_q == S_IDLE);

	// sequencer, window state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			seq_q         <= '0;
			newest_q      <= '0;
			window_q      <= '0;
			seen_q        <= 1'b0;
			diff_q        <= '0;
			gt_q          <= 1'b0;
			eq_q          <= 1'b0;
			base_q        <= '0;
			drain_q       <= '0;
			last_q        <= 1'b0;
			dup_q         <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= '0;
		end else begin
			// result taken, unless a new one is loaded in the same cycle
			if (m_axis_tvalid && m_axis_tready && (state_q != S_DONE)) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						seq_q   <= s_axis_tdata;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					gt_q    <= seq_q > newest_q;
					eq_q    <= seq_q == newest_q;
					diff_q  <= (seq_q > newest_q) ? (seq_q - newest_q) : (newest_q - seq_q);
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (!seen_q) begin
						dup_q    <= 1'b0;
						newest_q <= seq_q;
						seen_q   <= 1'b1;
						state_q  <= S_DONE;
					end else if (eq_q) begin
						dup_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (gt_q) begin
						dup_q    <= 1'b0;
						base_q   <= newest_q;
						newest_q <= seq_q;
						state_q  <= S_DRAIN;
						if (near) begin
							drain_q  <= window_q & ({awdt_pkg::WIN_W{1'b1}} << keep_sh);
							last_q   <= 1'b0;
							window_q <= (window_q << diff_lo) |
							            (awdt_pkg::WIN_W'(1) << bit_idx);
						end else begin
							drain_q  <= window_q;
							last_q   <= 1'b1;
							window_q <= '0;
						end
					end else if (near) begin
						dup_q   <= window_q[bit_idx];
						state_q <= S_DONE;
						if (!window_q[bit_idx]) begin
							window_q <= window_q | (awdt_pkg::WIN_W'(1) << bit_idx);
						end
					end else begin
						dup_q   <= hist_hit;
						state_q <= S_DONE;
					end
				end
				S_DRAIN: begin
					if (drain_q != '0) begin
						drain_q[lsb_idx] <= 1'b0;
					end else if (last_q) begin
						last_q <= 1'b0;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {window_q, newest_q};
						m_axis_tuser  <= {seen_q, dup_q};
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/awdt_cell.sv -----
// awdt_cell: one entry of the history chain, holds a sequence number,
// hands it to the next cell on a push and compares it against the key
// depends on awdt_pkg
module awdt_cell (
	input  logic                       clk,
	input  logic                       shift_en,
	input  logic [awdt_pkg::SEQ_W-1:0] data_in,
	input  logic [awdt_pkg::SEQ_W-1:0] key,
	input  logic                       valid,
	output logic [awdt_pkg::SEQ_W-1:0] data_out,
	output logic                       match
);

	logic [awdt_pkg::SEQ_W-1:0] value_q;
	logic                       match_q;

	// entry storage and registered compare
	always_ff @(posedge clk) begin
		if (shift_en) begin
			value_q <= data_in;
		end
		match_q <= valid && (value_q == key);
	end

	assign data_out = value_q;
	assign match    = match_q;

endmodule

// ----- rtl/awdt_history.sv -----
// awdt_history: fifo history of older sequence numbers as a row of cells,
// newest entry in cell 0, oldest falls off the far end when full
// depends on awdt_pkg and awdt_cell
module awdt_history #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  awdt_pkg::hist_ctrl_t ctrl,
	output logic                hit
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]           count_q;
	logic [awdt_pkg::SEQ_W-1:0] chain [DEPTH];
	logic [DEPTH-1:0]           match_vec;

	// fill count, saturates at the depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push && (count_q != CNT_W'(DEPTH))) begin
			count_q <= count_q + 1'b1;
		end
	end

	// row of cells, each shifts from its left neighbor on a push
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [awdt_pkg::SEQ_W-1:0] cell_in;
		if (k == 0) begin : g_head
			assign cell_in = ctrl.push_val;
		end else begin : g_body
			assign cell_in = chain[k-1];
		end
		awdt_cell u_cell (
			.clk      (clk),
			.shift_en (ctrl.push),
			.data_in  (cell_in),
			.key      (ctrl.key),
			.valid    (CNT_W'(k) < count_q),
			.data_out (chain[k]),
			.match    (match_vec[k])
		);
	end

	assign hit = |match_vec;

endmodule
